// ----- rtl/odd_cycle_count_by_vertex_set_core_macros.svh -----
// Assertion macros shared by the odd cycle counter checker.
`ifndef ODD_CYCLE_COUNT_BY_VERTEX_SET_CORE_MACROS_SVH
`define ODD_CYCLE_COUNT_BY_VERTEX_SET_CORE_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define OCC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, off while reset is high.
`define OCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

// Condition that must hold in the cycle after reset is seen.
`define OCC_ASSERT_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("%m: post-reset check failed");

`endif

// ----- rtl/occ_vs_pkg.sv -----
// Shared widths, codes and state encoding of the odd cycle counter.
package occ_vs_pkg;

   localparam int OP_W     = 2;
   localparam int VERTEX_W = 4;
   localparam int ROW_W    = 12;
   localparam int MASK_W   = 12;
   localparam int COUNT_W  = 26;
   localparam int VC_W     = 4;

   localparam logic [VC_W-1:0]    VC_RESET  = VC_W'(12);
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_RUN   = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SET_START,
      ST_PREAD,
      ST_PWAIT,
      ST_UPD,
      ST_CYC_WR,
      ST_QWAIT,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/odd_cycle_count_by_vertex_set_core.sv -----
// Odd directed cycle counter per vertex set, bitmask DP over path and cycle memories.
// Sequence: a load or spare op goes straight to the done state; a query reads the cycle
//   memory first; a run clears both memories, then walks every set and member in turn.
// Throughput: one request word at a time; a run does one path extension per cycle while
//   it extends a path's successors, and opens with a clearing sweep of both memories.
// Reset: synchronous; clears control, vertex_count to 12, adjacency rows; counts read 0.
module odd_cycle_count_by_vertex_set_core
   import occ_vs_pkg::*;
#(
   parameter int MAX_VERTICES = 12
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_op,
   input  logic [VERTEX_W-1:0] req_vertex,
   input  logic [ROW_W-1:0]    req_row_bits,
   input  logic [MASK_W-1:0]   req_mask,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [COUNT_W-1:0]  rsp_count,
   output logic                rsp_done_res,
   // configuration write channel
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [VC_W-1:0]     csr_vertex_count
);

   localparam int SET_W      = MAX_VERTICES;
   localparam int SET_DEPTH  = 1 << MAX_VERTICES;
   localparam int PATH_DEPTH = SET_DEPTH * MAX_VERTICES;
   localparam int V_W        = $clog2(MAX_VERTICES);
   localparam int PATH_AW    = $clog2(PATH_DEPTH);
   localparam logic [V_W-1:0] V_LAST = V_W'(MAX_VERTICES - 1);

   // Memory word index of path count (set, end vertex).
   function automatic logic [PATH_AW-1:0] path_addr(input logic [SET_W-1:0] s,
                                                     input logic [V_W-1:0]   v);
      return PATH_AW'(s) * PATH_AW'(MAX_VERTICES) + PATH_AW'(v);
   endfunction

   // Index of the lowest set bit; zero for an empty set.
   function automatic logic [V_W-1:0] low_index(input logic [SET_W-1:0] x);
      logic [V_W-1:0] r;
      r = '0;
      for (int i = SET_W - 1; i >= 0; i--) begin
         if (x[i]) r = V_W'(i);
      end
      return r;
   endfunction

   function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
      logic [COUNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
   endfunction

   // ---------------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------------
   state_type            state_ff, state_in;
   logic [VC_W-1:0]      vc_ff, vc_in;
   logic [SET_W-1:0]     adj_ff [MAX_VERTICES];
   logic [SET_W-1:0]     adj_in [MAX_VERTICES];
   logic                 ran_ff, ran_in;          // a run has filled the cycle memory
   logic [SET_W-1:0]     full_ff, full_in;        // vertices in use for this run
   logic [SET_W-1:0]     set_ff, set_in;          // current set (also clear sweep row)
   logic [V_W-1:0]       v_ff, v_in;              // current end vertex (also sweep column)
   logic [SET_W-1:0]     rest_ff, rest_in;        // members of the set not yet visited
   logic [V_W-1:0]       start_ff, start_in;      // lowest vertex of the set
   logic                 odd3_ff, odd3_in;        // set size odd and at least three
   logic [COUNT_W-1:0]   p_ff, p_in;              // path count being propagated
   logic [SET_W-1:0]     next_ff, next_in;        // successors still to extend to
   logic [COUNT_W-1:0]   cyc_acc_ff, cyc_acc_in;  // closing-path total of the set
   logic                 upd_vld_ff, upd_vld_in;  // an extension read is in flight
   logic [PATH_AW-1:0]   upd_addr_ff, upd_addr_in;
   logic                 qok_ff, qok_in;          // queried set is valid and filled
   logic [COUNT_W-1:0]   res_ff, res_in;          // finished count awaiting output
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   // ---------------------------------------------------------------------------------
   // Memories: path counts per (set, end vertex), cycle counts per set
   // ---------------------------------------------------------------------------------
   logic [COUNT_W-1:0]   path_mem [PATH_DEPTH];
   logic [COUNT_W-1:0]   cyc_mem  [SET_DEPTH];
   logic                 path_we;
   logic [PATH_AW-1:0]   path_waddr, path_raddr;
   logic [COUNT_W-1:0]   path_wdata, path_rdata_ff;
   logic                 cyc_we;
   logic [SET_W-1:0]     cyc_waddr, cyc_raddr;
   logic [COUNT_W-1:0]   cyc_wdata, cyc_rdata_ff;

   // ---------------------------------------------------------------------------------
   // Handshakes and helper terms
   // ---------------------------------------------------------------------------------
   logic                       req_acc, csr_acc, out_free;
   logic [SET_W-1:0]           rest_bit, next_bit, set_drop1, set_drop2, start_upper;
   logic [V_W-1:0]             rest_v, next_u;
   logic                       clr_last, seed_hit, mask_in_range;
   logic [MASK_W+SET_W-1:0]    mask_wide;
   logic [ROW_W+SET_W-1:0]     row_wide;

   assign req_stall    = (state_ff != ST_IDLE);
   assign req_acc      = req_valid && !req_stall;
   assign csr_ready    = 1'b1;
   assign csr_acc      = csr_valid && csr_ready;
   // The output register frees when empty or when its word leaves this cycle.
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_done_res = 1'b1;

   // Isolate the lowest member still to visit and the lowest pending successor.
   assign rest_bit  = rest_ff & (~rest_ff + SET_W'(1));
   assign rest_v    = low_index(rest_ff);
   assign next_bit  = next_ff & (~next_ff + SET_W'(1));
   assign next_u    = low_index(next_ff);

   // Size at least three: still nonzero after dropping the two lowest bits.
   assign set_drop1 = set_ff & (set_ff - SET_W'(1));
   assign set_drop2 = set_drop1 & (set_drop1 - SET_W'(1));

   // Successors must not lie below the set's start vertex.
   assign start_upper = ~((SET_W'(1) << start_ff) - SET_W'(1));

   // Clear sweep: last word, and single-vertex seed words that start at 1.
   assign clr_last  = (&set_ff) && (v_ff == V_LAST);
   assign seed_hit  = (set_ff == (SET_W'(1) << v_ff)) && full_ff[v_ff];

   // Fit the 12-bit mask and row fields onto the store width, either way round.
   assign mask_wide     = {{SET_W{1'b0}}, req_mask};
   assign mask_in_range = ((mask_wide >> SET_W) == '0);
   assign row_wide      = {{SET_W{1'b0}}, req_row_bits};

   // ---------------------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_op)
                  OP_RUN:   state_in = ST_CLEAR;
                  OP_QUERY: state_in = ST_QWAIT;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = (full_ff == '0) ? ST_DONE : ST_SET_START;
            end
         end
         ST_SET_START: state_in = ST_PREAD;
         ST_PREAD:     state_in = ST_PWAIT;
         ST_PWAIT:     state_in = ST_UPD;
         ST_UPD: begin
            if (next_ff == '0) begin
               state_in = (rest_ff != '0) ? ST_PREAD : ST_CYC_WR;
            end
         end
         ST_CYC_WR: state_in = (set_ff == full_ff) ? ST_DONE : ST_SET_START;
         ST_QWAIT:  state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Datapath and memory control
   // ---------------------------------------------------------------------------------
   always_comb begin
      vc_in        = csr_acc ? csr_vertex_count : vc_ff;
      adj_in       = adj_ff;
      ran_in       = ran_ff;
      full_in      = full_ff;
      set_in       = set_ff;
      v_in         = v_ff;
      rest_in      = rest_ff;
      start_in     = start_ff;
      odd3_in      = odd3_ff;
      p_in         = p_ff;
      next_in      = next_ff;
      cyc_acc_in   = cyc_acc_ff;
      upd_vld_in   = 1'b0;
      upd_addr_in  = upd_addr_ff;
      qok_in       = qok_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_count_in = rsp_count_ff;

      path_we    = 1'b0;
      path_waddr = path_addr(set_ff, v_ff);
      path_wdata = '0;
      path_raddr = path_addr(set_ff, rest_v);
      cyc_we     = 1'b0;
      cyc_waddr  = set_ff;
      cyc_wdata  = cyc_acc_ff;
      cyc_raddr  = mask_wide[SET_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               res_in = '0;
               case (req_op)
                  OP_LOAD: begin
                     // Drop rows for vertices the store does not have.
                     if (int'(req_vertex) < MAX_VERTICES) begin
                        adj_in[V_W'(req_vertex)] = row_wide[SET_W-1:0];
                     end
                  end
                  OP_RUN: begin
                     ran_in = 1'b1;
                     set_in = '0;
                     v_in   = '0;
                     // Counts above the store size act as the full store.
                     for (int i = 0; i < SET_W; i++) begin
                        full_in[i] = (i < int'(vc_ff));
                     end
                  end
                  OP_QUERY: begin
                     // The cycle memory read starts now; keep whether it counts.
                     qok_in = ran_ff && mask_in_range;
                  end
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            // Sweep both memories, seeding each single-vertex path of a vertex in use with one.
            path_we    = 1'b1;
            path_waddr = path_addr(set_ff, v_ff);
            path_wdata = seed_hit ? COUNT_W'(1) : '0;
            cyc_we     = (v_ff == '0);
            cyc_wdata  = '0;
            if (v_ff == V_LAST) begin
               v_in   = '0;
               set_in = set_ff + SET_W'(1);
            end else begin
               v_in = v_ff + V_W'(1);
            end
            if (clr_last) set_in = SET_W'(1);
         end
         ST_SET_START: begin
            rest_in    = set_ff;
            start_in   = low_index(set_ff);
            odd3_in    = (^set_ff) && (set_drop2 != '0);
            cyc_acc_in = '0;
         end
         ST_PREAD: begin
            // Issue the read of path count (set, v) for the lowest unvisited member.
            v_in    = rest_v;
            rest_in = rest_ff ^ rest_bit;
         end
         ST_PWAIT: begin
            p_in = path_rdata_ff;
            if (path_rdata_ff != '0) begin
               if (odd3_ff && adj_ff[v_ff][start_ff]) begin
                  cyc_acc_in = sat_add(cyc_acc_ff, path_rdata_ff);
               end
               next_in = adj_ff[v_ff] & ~set_ff & start_upper & full_ff;
            end else begin
               next_in = '0;
            end
         end
         ST_UPD: begin
            // Read one successor's path count per cycle, write it back in the next cycle.
            // Successors of one end vertex hit distinct words, so no overlap occurs.
            if (next_ff != '0) begin
               path_raddr  = path_addr(set_ff | next_bit, next_u);
               upd_addr_in = path_addr(set_ff | next_bit, next_u);
               upd_vld_in  = 1'b1;
               next_in     = next_ff ^ next_bit;
            end
            if (upd_vld_ff) begin
               path_we    = 1'b1;
               path_waddr = upd_addr_ff;
               path_wdata = sat_add(path_rdata_ff, p_ff);
            end
         end
         ST_CYC_WR: begin
            cyc_we    = 1'b1;
            cyc_waddr = set_ff;
            cyc_wdata = cyc_acc_ff;
            set_in    = set_ff + SET_W'(1);
         end
         ST_QWAIT: begin
            res_in = qok_ff ? cyc_rdata_ff : '0;
         end
         ST_DONE: begin
            // Hold the result until the output register is free, then advance.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = res_ff;
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vc_ff        <= VC_RESET;
         ran_ff       <= 1'b0;
         upd_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_VERTICES; i++) begin
            adj_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         vc_ff        <= vc_in;
         ran_ff       <= ran_in;
         upd_vld_ff   <= upd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         adj_ff       <= adj_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      full_ff      <= full_in;
      set_ff       <= set_in;
      v_ff         <= v_in;
      rest_ff      <= rest_in;
      start_ff     <= start_in;
      odd3_ff      <= odd3_in;
      p_ff         <= p_in;
      next_ff      <= next_in;
      cyc_acc_ff   <= cyc_acc_in;
      upd_addr_ff  <= upd_addr_in;
      qok_ff       <= qok_in;
      res_ff       <= res_in;
      rsp_count_ff <= rsp_count_in;
   end

   // ---------------------------------------------------------------------------------
   // Memory arrays, one write and one registered read each
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (path_we) path_mem[path_waddr] <= path_wdata;
      path_rdata_ff <= path_mem[path_raddr];
   end

   always_ff @(posedge clock) begin
      if (cyc_we) cyc_mem[cyc_waddr] <= cyc_wdata;
      cyc_rdata_ff <= cyc_mem[cyc_raddr];
   end

endmodule

// ----- rtl/occ_vs_checker.sv -----
// Port-level checker for the odd cycle counter, bound to the top level.
`include "odd_cycle_count_by_vertex_set_core_macros.svh"

module occ_vs_checker
   import occ_vs_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [COUNT_W-1:0]  rsp_count
);

   logic       req_acc, rsp_acc, rsp_held;
   logic [1:0] outstanding_ff, outstanding_in;

   assign req_acc  = req_valid && !req_stall;
   assign rsp_acc  = rsp_valid && !rsp_stall;
   assign rsp_held = rsp_valid && rsp_stall;

   // Track words accepted but not yet answered.
   always_comb begin
      outstanding_in = outstanding_ff + {1'b0, req_acc} - {1'b0, rsp_acc};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   `OCC_ASSERT_RESET(a_reset_empty, clock, reset, !rsp_valid)
   `OCC_ASSERT_IMPL(a_rsp_has_req, clock, reset, rsp_valid, outstanding_ff != 2'd0)
   `OCC_ASSERT_IMPL(a_two_deep, clock, reset, outstanding_ff == 2'd2, req_stall)
   `OCC_ASSERT_IMPL(a_depth_bound, clock, reset, 1'b1, outstanding_ff != 2'd3)
   `OCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_count))

endmodule

bind odd_cycle_count_by_vertex_set_core occ_vs_checker u_occ_vs_checker (.*);
